// ----- sv/pur_pkg.sv -----
// Shared types and constants for the Paeth row unfilter unit.
// No dependencies; every other file of the block refers to this package.
package pur_pkg;

    localparam int DEF_MAX_ROW_BYTES = 4096;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int HIST_DEPTH = 4;
    localparam int STEP_W     = 2;

    // Pixel format codes; codes 6 and 7 behave as one byte per pixel.
    typedef enum logic [2:0] {
        FMT_A1       = 3'd0,
        FMT_A8       = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_ARGB1555 = 3'd3,
        FMT_RGB888   = 3'd4,
        FMT_RGBA8888 = 3'd5
    } fmt_t;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_idx_t;

    localparam logic [2:0]            RST_PIXEL_FORMAT = 3'(FMT_A8);
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 16'd1;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 16'd1;

    // Per-byte control that travels with a byte from acceptance to the
    // reconstruction stage.
    typedef struct packed {
        logic              first_row;
        logic              no_left;
        logic              row_end;
        logic              image_end;
        logic [STEP_W-1:0] step_sel;
    } ctl_t;

endpackage

// ----- sv/pur_if.sv -----
// Request channels of the Paeth row unfilter unit: filtered bytes in,
// reconstructed bytes out. Depends on pur_pkg for the byte width.
interface pur_in_if;
    logic                        valid;
    logic                        ready;
    logic [pur_pkg::BYTE_W-1:0]  filtered_byte;

    modport source (output valid, output filtered_byte, input ready);
    modport sink (input valid, input filtered_byte, output ready);
endinterface

interface pur_out_if;
    logic                        valid;
    logic                        ready;
    logic [pur_pkg::BYTE_W-1:0]  pixel_byte;
    logic                        row_end;
    logic                        image_end;

    modport source (output valid, output pixel_byte, output row_end, output image_end,
                    input ready);
    modport sink (input valid, input pixel_byte, input row_end, input image_end,
                  output ready);
endinterface

// ----- sv/pur_line_store.sv -----
// Line store: one synchronous RAM holding the previous reconstructed row.
// One read port with registered data, one write port. Depends on pur_pkg.
module pur_line_store #(
    parameter int DEPTH  = pur_pkg::DEF_MAX_ROW_BYTES,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [pur_pkg::BYTE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [pur_pkg::BYTE_W-1:0] wr_data
);

    logic [pur_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [pur_pkg::BYTE_W-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/pur_recon.sv -----
// Reconstruction stage: left and upper-left histories, the Sub and Paeth
// predictors and the final add. Depends on pur_pkg.
module pur_recon (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          commit,
    input  pur_pkg::ctl_t                 ctl,
    input  logic [pur_pkg::BYTE_W-1:0]    filt,
    input  logic [pur_pkg::BYTE_W-1:0]    mem_data,
    input  logic                          fwd_hit,
    input  logic [pur_pkg::BYTE_W-1:0]    fwd_data,
    output logic [pur_pkg::BYTE_W-1:0]    res
);

    localparam int BW = pur_pkg::BYTE_W;
    localparam int DW = BW + 2;

    logic [BW-1:0] left_reg [pur_pkg::HIST_DEPTH];
    logic [BW-1:0] ul_reg   [pur_pkg::HIST_DEPTH];
    logic [BW-1:0] above;
    logic [BW-1:0] a_val;
    logic [BW-1:0] c_val;
    logic [BW-1:0] pred;
    logic signed [DW-1:0] sa;
    logic signed [DW-1:0] sb;
    logic signed [DW-1:0] sc;
    logic signed [DW-1:0] pa;
    logic signed [DW-1:0] pb;
    logic signed [DW-1:0] pc;

    // The first row has no byte above; a byte written by the previous
    // byte in the same cycle it is read comes from the forward path.
    always_comb
    begin
        if (ctl.first_row)
        begin
            above = '0;
        end
        else if (fwd_hit)
        begin
            above = fwd_data;
        end
        else
        begin
            above = mem_data;
        end
    end

    assign a_val = left_reg[ctl.step_sel];
    assign c_val = ul_reg[ctl.step_sel];

    always_comb
    begin
        sa = DW'(signed'({1'b0, a_val}));
        sb = DW'(signed'({1'b0, above}));
        sc = DW'(signed'({1'b0, c_val}));
        pa = (sb >= sc) ? (sb - sc) : (sc - sb);
        pb = (sa >= sc) ? (sa - sc) : (sc - sa);
        pc = (sa + sb >= sc + sc) ? (sa + sb - sc - sc) : (sc + sc - sa - sb);
        priority if (pa <= pb && pa <= pc)
        begin
            pred = a_val;
        end
        else if (pb <= pc)
        begin
            pred = above;
        end
        else
        begin
            pred = c_val;
        end
    end

    always_comb
    begin
        unique case ({ctl.first_row, ctl.no_left})
            2'b11:   res = filt;
            2'b10:   res = filt + a_val;
            2'b01:   res = filt + above;
            default: res = filt + pred;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pur_pkg::HIST_DEPTH; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (clear || (commit && ctl.row_end))
        begin
            for (int i = 0; i < pur_pkg::HIST_DEPTH; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (commit)
        begin
            for (int i = pur_pkg::HIST_DEPTH - 1; i > 0; i--)
            begin
                left_reg[i] <= left_reg[i-1];
                ul_reg[i]   <= ul_reg[i-1];
            end
            left_reg[0] <= res;
            ul_reg[0]   <= above;
        end
    end

endmodule

// ----- sv/paeth_row_unfilter_unit.sv -----
// Top level of the Paeth row unfilter unit: counters, pipeline control,
// output register. Depends on pur_pkg, pur_if, pur_line_store, pur_recon.
//
// The unit takes one filtered byte per request and returns one reconstructed
// byte per request, with flags for the last byte of a row and of the image.
// It sustains one byte per clock cycle unless the output stalls; each byte
// goes through the line-store read stage and then the output register. The
// rate is set by the single line-store RAM, which does one read and one write
// per cycle; a byte that reads the entry written by the byte just before it
// (rows of one byte) takes the value from a forward path. The first row of an
// image is undone with the Sub filter, later rows with the Paeth predictor
// against the previous row. Row length follows from the pixel format and
// image width and saturates at MAX_ROW_BYTES. Any write on the configuration
// port, also to an unused index, restarts the image; the user makes writes
// only while the unit is idle, which the unit does not enforce. The line
// store needs no clearing after reset, so requests are taken right away.
module paeth_row_unfilter_unit #(
    parameter int MAX_ROW_BYTES = pur_pkg::DEF_MAX_ROW_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pur_in_if.sink                          filt_ch,
    pur_out_if.source                       pix_ch,
    input  logic                            cfg_we,
    input  logic [pur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pur_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int BW     = pur_pkg::BYTE_W;
    localparam int CW     = pur_pkg::CFG_DATA_W;
    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int N_W    = CW + 2;

    // Configuration registers.
    logic [2:0]    fmt_reg;
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;

    // Position of the next accepted byte.
    logic [ADDR_W-1:0] col_reg;
    logic [CW-1:0]     row_reg;

    // Stage holding a byte while its line-store read completes.
    logic                a_valid_reg;
    logic [BW-1:0]       a_byte_reg;
    logic [ADDR_W-1:0]   a_addr_reg;
    pur_pkg::ctl_t       a_ctl_reg;
    logic                fwd_hit_reg;
    logic [BW-1:0]       fwd_data_reg;

    // Output register.
    logic          out_valid_reg;
    logic [BW-1:0] out_byte_reg;
    logic          out_rend_reg;
    logic          out_iend_reg;

    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     h_eff;
    logic [N_W-1:0]    n_raw;
    logic [LEN_W-1:0]  row_len;
    logic [pur_pkg::STEP_W-1:0] step_sel;
    logic [LEN_W-1:0]  col_inc;
    logic [CW:0]       row_inc;
    logic              rend;
    logic              iend;
    logic              accept;
    logic              a_adv;
    logic [BW-1:0]     mem_data;
    logic [BW-1:0]     res;
    pur_pkg::ctl_t     ctl_new;

    assign w_eff = (width_reg == '0) ? CW'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? CW'(1) : height_reg;

    // Row length in bytes and pixel step for the current format.
    always_comb
    begin
        unique case (pur_pkg::fmt_t'(fmt_reg))
            pur_pkg::FMT_A1:
            begin
                n_raw    = (N_W'(w_eff) + N_W'(7)) >> 3;
                step_sel = 2'd0;
            end
            pur_pkg::FMT_RGB565, pur_pkg::FMT_ARGB1555:
            begin
                n_raw    = N_W'(w_eff) << 1;
                step_sel = 2'd1;
            end
            pur_pkg::FMT_RGB888:
            begin
                n_raw    = N_W'(w_eff) + (N_W'(w_eff) << 1);
                step_sel = 2'd2;
            end
            pur_pkg::FMT_RGBA8888:
            begin
                n_raw    = N_W'(w_eff) << 2;
                step_sel = 2'd3;
            end
            default:
            begin
                n_raw    = N_W'(w_eff);
                step_sel = 2'd0;
            end
        endcase
    end

    assign row_len = (n_raw > N_W'(MAX_ROW_BYTES)) ? LEN_W'(MAX_ROW_BYTES)
                                                   : LEN_W'(n_raw);

    assign col_inc = LEN_W'(col_reg) + LEN_W'(1);
    assign row_inc = (CW+1)'(row_reg) + (CW+1)'(1);
    assign rend    = (col_inc >= row_len);
    assign iend    = rend && (row_inc >= (CW+1)'(h_eff));

    always_comb
    begin
        ctl_new.first_row = (row_reg == '0);
        ctl_new.no_left   = (col_reg <= ADDR_W'(step_sel));
        ctl_new.row_end   = rend;
        ctl_new.image_end = iend;
        ctl_new.step_sel  = step_sel;
    end

    // The stage advances when the output register is free or being drained;
    // a new byte enters whenever the stage is empty or advancing.
    assign a_adv         = a_valid_reg && (!out_valid_reg || pix_ch.ready);
    assign filt_ch.ready = !a_valid_reg || !out_valid_reg || pix_ch.ready;
    assign accept        = filt_ch.valid && filt_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= pur_pkg::RST_PIXEL_FORMAT;
            width_reg  <= pur_pkg::RST_IMAGE_WIDTH;
            height_reg <= pur_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (pur_pkg::cfg_idx_t'(cfg_index))
                pur_pkg::CFG_PIXEL_FORMAT: fmt_reg    <= cfg_data[2:0];
                pur_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                pur_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Any configuration write restarts the image.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (rend)
            begin
                col_reg <= '0;
                row_reg <= iend ? '0 : row_inc[CW-1:0];
            end
            else
            begin
                col_reg <= col_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers. The forward flag marks a byte whose line-store
    // entry is written by the byte leaving the stage on the same edge.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_byte_reg   <= filt_ch.filtered_byte;
            a_addr_reg   <= col_reg;
            a_ctl_reg    <= ctl_new;
            fwd_hit_reg  <= a_adv && (a_addr_reg == col_reg);
            fwd_data_reg <= res;
        end
        if (a_adv)
        begin
            out_byte_reg <= res;
            out_rend_reg <= a_ctl_reg.row_end;
            out_iend_reg <= a_ctl_reg.image_end;
        end
    end

    pur_line_store #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mem_data),
        .wr_en   (a_adv),
        .wr_addr (a_addr_reg),
        .wr_data (res)
    );

    pur_recon u_recon (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_we),
        .commit   (a_adv),
        .ctl      (a_ctl_reg),
        .filt     (a_byte_reg),
        .mem_data (mem_data),
        .fwd_hit  (fwd_hit_reg),
        .fwd_data (fwd_data_reg),
        .res      (res)
    );

    assign pix_ch.valid     = out_valid_reg;
    assign pix_ch.pixel_byte = out_byte_reg;
    assign pix_ch.row_end   = out_rend_reg;
    assign pix_ch.image_end = out_iend_reg;

    // The column never reaches the row length.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(col_reg) < row_len)
        else $error("column count reached the row length");

    // A byte held in the read stage stays there with its address.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_addr_reg)))
        else $error("read stage lost a stalled byte");

    // Input is refused while both stages are full and the output is stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && out_valid_reg && !pix_ch.ready) |-> !filt_ch.ready)
        else $error("input accepted with no room");

    // The last byte of an image is also the last of its row.
    a_iend_rend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_iend_reg |-> out_rend_reg)
        else $error("image end without row end");

    // A configuration write restarts the image.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0 && row_reg == '0))
        else $error("configuration write did not restart the image");

endmodule

// ----- dv/testbench.sv -----
// Testbench for paeth_row_unfilter_unit: streams filtered bytes through the unit
// and checks every reconstructed byte against a predictor of its own.
// Depends on pur_pkg, pur_if and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

    // The line store holds one full row; rows saturate at this length.
    localparam int LINE_BYTES = pur_pkg::DEF_MAX_ROW_BYTES;

    // Register index past the end of the list: a write there changes no register
    // but still restarts the image.
    localparam logic [pur_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // Format codes outside the list; the unit treats both as one byte per pixel.
    localparam logic [2:0] FMT_SPARE_LO = 3'd6;
    localparam logic [2:0] FMT_SPARE_HI = 3'd7;

    // Random part of the run, counted in accepted filtered bytes.
    localparam int unsigned RANDOM_BYTES = 2000;

    // Cycles with no accepted request on either channel before the run is
    // declared hung. Stalls are short random runs, so this is far above any
    // correct gap.
    localparam int unsigned STALL_LIMIT = 2000;

    // The unit returns each byte through its read stage and output register; this
    // slack covers that with margin at the end of the run and before register writes.
    localparam int unsigned SETTLE_CYCLES = 8;

    // Chance, in percent per cycle, that either side holds off.
    localparam int unsigned IDLE_PCT = 14;

    typedef struct {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
    } recon_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [pur_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pur_pkg::CFG_DATA_W-1:0] cfg_data;

    pur_in_if  filt_ch ();
    pur_out_if pix_ch ();

    paeth_row_unfilter_unit #(
        .MAX_ROW_BYTES (LINE_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .filt_ch   (filt_ch),
        .pix_ch    (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state. It mirrors what the unit keeps: the previous row, the
    // last few reconstructed bytes and line-store bytes of the current row,
    // the column and row position, and the three registers.
    // ------------------------------------------------------------------
    logic [7:0]  prior_row [LINE_BYTES];
    logic [7:0]  left_hist [pur_pkg::HIST_DEPTH];
    logic [7:0]  upleft_hist [pur_pkg::HIST_DEPTH];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [2:0]  fmt_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    // Reconstructed bytes that have been predicted but not yet returned, in
    // the order the filtered bytes were accepted.
    recon_t      pending_pixels [$];

    int unsigned accepted_bytes;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // While set, neither side holds off: a stretch of back-to-back requests.
    bit          burst_mode;

    // Bytes per pixel, which is also how far back the left neighbor sits.
    function automatic int unsigned pixel_step(input logic [2:0] fmt);
        case (fmt)
            pur_pkg::FMT_RGB565, pur_pkg::FMT_ARGB1555: return 2;
            pur_pkg::FMT_RGB888:                        return 3;
            pur_pkg::FMT_RGBA8888:                      return 4;
            default:                                    return 1;
        endcase
    endfunction

    // Bytes in one row for the current settings. A zero width counts as one
    // pixel, and the length saturates at the line store's size.
    function automatic int unsigned row_length();
        int unsigned w;
        int unsigned n;
        w = (width_reg == 16'd0) ? 1 : int'(width_reg);
        case (fmt_reg)
            pur_pkg::FMT_A1:                            n = (w + 7) >> 3;
            pur_pkg::FMT_RGB565, pur_pkg::FMT_ARGB1555: n = w << 1;
            pur_pkg::FMT_RGB888:                        n = w * 3;
            pur_pkg::FMT_RGBA8888:                      n = w << 2;
            default:                                    n = w;
        endcase
        if (n > LINE_BYTES)
            n = LINE_BYTES;
        return n;
    endfunction

    function automatic int unsigned image_bytes();
        return row_length() * ((height_reg == 16'd0) ? 1 : int'(height_reg));
    endfunction

    // Paeth predictor: pick whichever of left, above and upper-left lies
    // closest to left + above - upper-left, ties going to left, then above.
    function automatic logic [7:0] paeth_pick(input logic [7:0] left_b,
                                              input logic [7:0] above_b,
                                              input logic [7:0] upleft_b);
        int p;
        int da;
        int db;
        int dc;
        p  = int'(left_b) + int'(above_b) - int'(upleft_b);
        da = int'(left_b) - p;
        db = int'(above_b) - p;
        dc = int'(upleft_b) - p;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            return left_b;
        if (db <= dc)
            return above_b;
        return upleft_b;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < pur_pkg::HIST_DEPTH; i++)
        begin
            left_hist[i]   = 8'h00;
            upleft_hist[i] = 8'h00;
        end
    endfunction

    function automatic void restart_image();
        clear_history();
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Works out the reconstructed byte and its flags for one accepted filtered
    // byte, and advances the predictor state.
    function automatic recon_t unfilter_byte(input logic [7:0] fb);
        recon_t      r;
        int unsigned xs;
        int unsigned len;
        int unsigned rows;
        int unsigned pos;
        logic [7:0]  above_b;
        logic [7:0]  res;
        xs   = pixel_step(fmt_reg);
        len  = row_length();
        rows = (height_reg == 16'd0) ? 1 : int'(height_reg);
        pos  = (col_pos < LINE_BYTES) ? col_pos : LINE_BYTES - 1;
        above_b = 8'h00;
        if (row_pos == 0)
        begin
            // First row: Sub filter; the first pixel has no left neighbor.
            res = (col_pos < xs) ? fb : fb + left_hist[xs - 1];
        end
        else
        begin
            above_b = prior_row[pos];
            if (col_pos < xs)
                res = fb + above_b;
            else
                res = fb + paeth_pick(left_hist[xs - 1], above_b, upleft_hist[xs - 1]);
        end
        prior_row[pos] = res;

        for (int i = pur_pkg::HIST_DEPTH - 1; i > 0; i--)
        begin
            left_hist[i]   = left_hist[i - 1];
            upleft_hist[i] = upleft_hist[i - 1];
        end
        left_hist[0]   = res;
        upleft_hist[0] = above_b;

        r.pixel     = res;
        r.row_end   = (col_pos + 1 >= len);
        r.image_end = 1'b0;
        if (r.row_end)
        begin
            col_pos = 0;
            clear_history();
            if (row_pos + 1 >= rows)
            begin
                r.image_end = 1'b1;
                row_pos     = 0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks. Every one of them is entered and left just after
    // a falling edge, so all inputs change on falling edges. A task that
    // leaves valid high lets the next request follow with no gap.
    // ------------------------------------------------------------------

    // Offers one filtered byte, waits for the request to be taken, and queues
    // the byte the unit must return for it.
    task automatic send_filtered(input logic [7:0] fb);
        if (!burst_mode)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                filt_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        filt_ch.valid         <= 1'b1;
        filt_ch.filtered_byte <= fb;
        @(posedge clk);
        while (!filt_ch.ready)
            @(posedge clk);
        pending_pixels.push_back(unfilter_byte(fb));
        accepted_bytes++;
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted byte has come back. The loop
    // always waits for a falling edge before it checks, so valid is never lowered
    // and raised in the same step.
    task automatic pause_for_results();
        filt_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // Writes one register. Only called once the unit has gone idle; any write,
    // also to the spare index, makes the next byte the first of a new image.
    task automatic write_reg(input logic [pur_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pur_pkg::CFG_DATA_W-1:0] data);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pur_pkg::CFG_PIXEL_FORMAT: fmt_reg    = data[2:0];
            pur_pkg::CFG_IMAGE_WIDTH:  width_reg  = data;
            pur_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
        restart_image();
    endtask

    // ------------------------------------------------------------------
    // Result side: the receiver stalls at random, and every returned byte is
    // checked against the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pix_ch.ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        recon_t exp_r;
        if (rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_byte %0h with no request waiting",
                       pix_ch.pixel_byte);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_pixels.pop_front();
                if (pix_ch.pixel_byte !== exp_r.pixel)
                begin
                    $error("pixel_byte mismatch: expected %0h, actual %0h",
                           exp_r.pixel, pix_ch.pixel_byte);
                    mismatch_count++;
                end
                if (pix_ch.row_end !== exp_r.row_end)
                begin
                    $error("row_end mismatch: expected %0b, actual %0b",
                           exp_r.row_end, pix_ch.row_end);
                    mismatch_count++;
                end
                if (pix_ch.image_end !== exp_r.image_end)
                begin
                    $error("image_end mismatch: expected %0b, actual %0b",
                           exp_r.image_end, pix_ch.image_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a run that stops accepting requests on both channels for too
    // long has hung, whether on the input side or with results still owed.
    always @(posedge clk)
    begin
        if ((filt_ch.valid === 1'b1 && filt_ch.ready === 1'b1) ||
            (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the unit is A8, one pixel wide and one row high, so every
    // byte is an image of its own and passes through unchanged.
    task automatic test_reset_state();
        logic [7:0] seq [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        foreach (seq[i])
            send_filtered(seq[i]);
        pause_for_results();
    endtask

    // A small A8 image: the first row is undone with Sub, the later rows with
    // Paeth, and the first byte of each later row takes only the byte above.
    task automatic test_sub_then_paeth();
        logic [7:0] seq [6] = '{8'hFF, 8'h01, 8'h10, 8'hF0, 8'h00, 8'hFF};
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, pur_pkg::FMT_A8});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'd2);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        foreach (seq[i])
            send_filtered(seq[i]);
        pause_for_results();
    endtask

    // One RGB888 pixel per row: every byte sits inside the first pixel step,
    // so none has a left neighbor.
    task automatic test_pixel_step_start();
        logic [7:0] seq [6] = '{8'h80, 8'h7F, 8'hFF, 8'h80, 8'h81, 8'h01};
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, pur_pkg::FMT_RGB888});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'd1);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        foreach (seq[i])
            send_filtered(seq[i]);
        pause_for_results();
    endtask

    // An unknown format code acts as A8, and zero width and height act as one.
    task automatic test_unknown_format_zero_size();
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, FMT_SPARE_HI});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'd0);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        send_filtered(8'h5A);
        send_filtered(8'hA5);
        pause_for_results();
    endtask

    // A1 packs eight pixels in a byte: nine pixels make a two-byte row.
    task automatic test_packed_rows();
        logic [7:0] seq [4] = '{8'hC3, 8'h3C, 8'hFF, 8'h00};
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, pur_pkg::FMT_A1});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'd9);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        foreach (seq[i])
            send_filtered(seq[i]);
        pause_for_results();
    endtask

    // The widest setting in the RGB888 format: the row saturates at the line
    // store's size, whose length is not a whole number of pixels. One row is
    // enough to show where the row ends.
    task automatic test_long_rows();
        int unsigned n;
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, pur_pkg::FMT_RGB888});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd1);
        n = image_bytes();
        for (int unsigned k = 0; k < n; k++)
            send_filtered(8'($urandom_range(0, 255)));
        pause_for_results();
    endtask

    // The tallest setting with one-byte rows: each byte reads the store entry
    // the byte just before it wrote. The image is cut short by a write to the
    // spare index, which must restart it without changing the height.
    task automatic test_tall_image();
        write_reg(pur_pkg::CFG_PIXEL_FORMAT, {13'd0, FMT_SPARE_LO});
        write_reg(pur_pkg::CFG_IMAGE_WIDTH, 16'd1);
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
        for (int unsigned k = 0; k < 40; k++)
            send_filtered(8'($urandom_range(0, 255)));
        pause_for_results();
        write_reg(CFG_SPARE_IDX, 16'hA5A5);
        for (int unsigned k = 0; k < 3; k++)
            send_filtered(8'($urandom_range(0, 255)));
        pause_for_results();
        write_reg(pur_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        for (int unsigned k = 0; k < 3; k++)
            send_filtered(8'($urandom_range(0, 255)));
        pause_for_results();
    endtask

    // Random settings, each followed by one to three whole images so that the
    // counts wrap into a new image. Now and then the last image is cut short
    // and the next register write restarts it, the sender pauses mid-image
    // until all results are back, or the bytes are drawn from a few values so
    // that the predictor meets ties. One stretch runs with no idling at all.
    task automatic test_random_images();
        int unsigned target;
        int unsigned iter;
        int unsigned images;
        int unsigned total;
        int unsigned n;
        int unsigned stall_at;
        logic [2:0]  fmt_code;
        logic [12:0] fmt_upper;
        logic [15:0] w;
        logic [15:0] h;
        bit          smooth;
        logic [7:0]  fb;
        target = accepted_bytes + RANDOM_BYTES;
        iter   = 0;
        while (accepted_bytes < target)
        begin
            burst_mode = (iter >= 3 && iter < 9);
            fmt_code   = 3'($urandom_range(0, 7));
            fmt_upper  = ($urandom_range(3) == 0) ? 13'($urandom) : 13'd0;
            if ($urandom_range(99) < 85)
            begin
                w = 16'($urandom_range(0, 12));
                h = 16'($urandom_range(0, 6));
            end
            else
            begin
                w = 16'($urandom_range(13, 200));
                h = 16'($urandom_range(0, 2));
            end

            if ($urandom_range(3) == 0)
                write_reg(CFG_SPARE_IDX, 16'($urandom));
            if ($urandom_range(4) != 0)
                write_reg(pur_pkg::CFG_PIXEL_FORMAT, {fmt_upper, fmt_code});
            if ($urandom_range(4) != 0)
                write_reg(pur_pkg::CFG_IMAGE_WIDTH, w);
            if ($urandom_range(4) != 0)
                write_reg(pur_pkg::CFG_IMAGE_HEIGHT, h);

            images = $urandom_range(1, 3);
            total  = image_bytes();
            for (int unsigned img = 0; img < images; img++)
            begin
                n = total;
                if (img == images - 1 && $urandom_range(5) == 0)
                    n = $urandom_range(1, total);
                stall_at = ($urandom_range(9) == 0) ? $urandom_range(0, n - 1) : n;
                smooth   = ($urandom_range(3) == 0);
                for (int unsigned k = 0; k < n; k++)
                begin
                    if (k == stall_at)
                        pause_for_results();
                    if (smooth)
                    begin
                        case ($urandom_range(2))
                            0:       fb = 8'h00;
                            1:       fb = 8'h01;
                            default: fb = 8'hFF;
                        endcase
                    end
                    else
                        fb = 8'($urandom_range(0, 255));
                    send_filtered(fb);
                end
            end
            pause_for_results();
            iter++;
        end
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = pur_pkg::CFG_PIXEL_FORMAT;
        cfg_data              = '0;
        filt_ch.valid         = 1'b0;
        filt_ch.filtered_byte = 8'h00;
        burst_mode            = 1'b0;
        accepted_bytes        = 0;
        fmt_reg               = pur_pkg::RST_PIXEL_FORMAT;
        width_reg             = pur_pkg::RST_IMAGE_WIDTH;
        height_reg            = pur_pkg::RST_IMAGE_HEIGHT;
        foreach (prior_row[i])
            prior_row[i] = 8'h00;
        restart_image();

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_sub_then_paeth();
        test_pixel_step_start();
        test_unknown_format_zero_size();
        test_packed_rows();
        test_long_rows();
        test_tall_image();
        test_random_images();

        // Every request has been taken and answered; wait out the settle time so the
        // unit can show any stray result before the verdict.
        pause_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
